FILE: rtl/fnoa_pkg.sv
// ----------------------------------------------------------------------------
// fnoa_pkg
// Shared types, constants and functions of the face non-orthogonality block.
// ----------------------------------------------------------------------------
package fnoa_pkg;

	localparam int NORM_BIT = 29;
	localparam int NW = NORM_BIT + 2;
	localparam int QW = 64;
	localparam int SQW = 2 * NORM_BIT + 4;
	localparam int RW = SQW / 2;
	localparam int XW = 36;
	localparam int ZW = 34;
	localparam int ZQ = 24;
	localparam int CORDIC_ITERS = 28;
	localparam int OUT_W = 16;
	localparam longint RAD2DEG_Q24 = 64'sd961263669;
	localparam logic signed [ZW-1:0] Z90 = ZW'(64'sd90 <<< ZQ);
	localparam logic signed [ZW-1:0] Z180 = ZW'(64'sd180 <<< ZQ);

	typedef struct packed {
		logic vld;
		logic zero;
	} fnoa_ctl_t;

	function automatic logic [5:0] top_bit(input logic [63:0] a);
		logic [5:0] b;
		b = '0;
		for (int k = 0; k < 64; k++) begin
			if (a[k]) b = 6'(k);
		end
		return b;
	endfunction

	function automatic logic signed [ZW-1:0] atan_q24(input int i);
		logic signed [ZW-1:0] a;
		case (i)
			0: a = 34'sd754974720;
			1: a = 34'sd445687602;
			2: a = 34'sd235489088;
			3: a = 34'sd119537938;
			4: a = 34'sd60000934;
			5: a = 34'sd30029717;
			6: a = 34'sd15018523;
			7: a = 34'sd7509720;
			8: a = 34'sd3754917;
			9: a = 34'sd1877466;
			10: a = 34'sd938734;
			11: a = 34'sd469367;
			default: a = ZW'((RAD2DEG_Q24 + (64'sd1 <<< (i - 1))) >>> i);
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/fnoa_if.sv
// ----------------------------------------------------------------------------
// fnoa_if
// Valid/ready channels: one face per beat in, one angle per beat out.
// ----------------------------------------------------------------------------
interface fnoa_face_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] owner_x;
	logic signed [W-1:0] owner_y;
	logic signed [W-1:0] owner_z;
	logic signed [W-1:0] neighbour_x;
	logic signed [W-1:0] neighbour_y;
	logic signed [W-1:0] neighbour_z;
	logic signed [W-1:0] area_x;
	logic signed [W-1:0] area_y;
	logic signed [W-1:0] area_z;

	modport source (output valid, owner_x, owner_y, owner_z, neighbour_x, neighbour_y,
		neighbour_z, area_x, area_y, area_z, input ready);
	modport sink (input valid, owner_x, owner_y, owner_z, neighbour_x, neighbour_y,
		neighbour_z, area_x, area_y, area_z, output ready);
endinterface

interface fnoa_angle_if;
	logic valid;
	logic ready;
	logic [15:0] angle_degrees;

	modport source (output valid, angle_degrees, input ready);
	modport sink (input valid, angle_degrees, output ready);
endinterface

FILE: rtl/fnoa_norm.sv
// ----------------------------------------------------------------------------
// fnoa_norm
// Forms d = neighbour - owner and scales d and the area vector so the
// largest component magnitude lies in [2^29, 2^30). Three stages.
// ----------------------------------------------------------------------------
module fnoa_norm
	import fnoa_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  fnoa_ctl_t                     ctl,
	input  logic signed [COORD_WIDTH-1:0] owner [3],
	input  logic signed [COORD_WIDTH-1:0] neighbour [3],
	input  logic signed [COORD_WIDTH-1:0] area [3],
	output fnoa_ctl_t                     ctl_n,
	output logic signed [NW-1:0]          d_n [3],
	output logic signed [NW-1:0]          s_n [3]
);
	localparam int DW = COORD_WIDTH + 1;

	fnoa_ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] d_s2 [3];
	logic signed [COORD_WIDTH-1:0] s_s1 [3];
	logic signed [COORD_WIDTH-1:0] s_s2 [3];
	logic signed [NW-1:0] d_s3 [3];
	logic signed [NW-1:0] s_s3 [3];
	logic [5:0] bd_s2, bs_s2;
	logic [63:0] max_d, max_s;
	logic [NW-1:0] max_n;

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [NW-1:0] scale(input logic signed [63:0] v,
		input logic [5:0] b);
		logic [63:0] m;
		logic [63:0] r;
		m = mag(v);
		if (b > 6'(NORM_BIT)) begin
			m = m >> (b - 6'(NORM_BIT));
			r = v[63] ? (64'd0 - m) : m;
		end else begin
			r = 64'(v) << (6'(NORM_BIT) - b);
		end
		return NW'(r);
	endfunction

	always_comb begin
		max_d = '0;
		max_s = '0;
		for (int i = 0; i < 3; i++) begin
			if (mag(64'(d_s1[i])) > max_d) max_d = mag(64'(d_s1[i]));
			if (mag(64'(s_s1[i])) > max_s) max_s = mag(64'(s_s1[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl;
			ctl_s2.vld <= ctl_s1.vld;
			ctl_s2.zero <= ctl_s1.zero | (max_d == '0) | (max_s == '0);
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DW'(neighbour[i]) - DW'(owner[i]);
				s_s1[i] <= area[i];
				d_s2[i] <= d_s1[i];
				s_s2[i] <= s_s1[i];
				d_s3[i] <= scale(64'(d_s2[i]), bd_s2);
				s_s3[i] <= scale(64'(s_s2[i]), bs_s2);
			end
			bd_s2 <= top_bit(max_d);
			bs_s2 <= top_bit(max_s);
		end
	end

	assign ctl_n = ctl_s3;
	assign d_n = d_s3;
	assign s_n = s_s3;

	always_comb begin
		max_n = '0;
		for (int i = 0; i < 3; i++) begin
			if (NW'(mag(64'(d_s3[i]))) > max_n) max_n = NW'(mag(64'(d_s3[i])));
		end
	end

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.vld && !ctl_s3.zero |-> max_n[NORM_BIT] && !max_n[NORM_BIT+1])
		else $error("normalized d out of range");
endmodule

FILE: rtl/fnoa_prod.sv
// ----------------------------------------------------------------------------
// fnoa_prod
// Dot and cross products of the normalized vectors, then a common right
// shift so the largest magnitude drops below 2^30. Four stages.
// ----------------------------------------------------------------------------
module fnoa_prod
	import fnoa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  fnoa_ctl_t            ctl_n,
	input  logic signed [NW-1:0] d_n [3],
	input  logic signed [NW-1:0] s_n [3],
	output fnoa_ctl_t            ctl_p,
	output logic signed [NW-1:0] q_p [4]
);
	localparam int PW = 2 * NW;

	fnoa_ctl_t ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic signed [PW-1:0] p_s4 [9];
	logic signed [QW-1:0] q_s5 [4];
	logic signed [QW-1:0] q_s6 [4];
	logic signed [NW-1:0] q_s7 [4];
	logic [5:0] tb_s6;
	logic [63:0] max_q;

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	always_comb begin
		max_q = '0;
		for (int i = 0; i < 4; i++) begin
			if (mag(q_s5[i]) > max_q) max_q = mag(q_s5[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_n;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s4[0] <= d_n[0] * s_n[0];
			p_s4[1] <= d_n[1] * s_n[1];
			p_s4[2] <= d_n[2] * s_n[2];
			p_s4[3] <= d_n[1] * s_n[2];
			p_s4[4] <= d_n[2] * s_n[1];
			p_s4[5] <= d_n[2] * s_n[0];
			p_s4[6] <= d_n[0] * s_n[2];
			p_s4[7] <= d_n[0] * s_n[1];
			p_s4[8] <= d_n[1] * s_n[0];
			q_s5[0] <= QW'(p_s4[0]) + QW'(p_s4[1]) + QW'(p_s4[2]);
			q_s5[1] <= QW'(p_s4[3]) - QW'(p_s4[4]);
			q_s5[2] <= QW'(p_s4[5]) - QW'(p_s4[6]);
			q_s5[3] <= QW'(p_s4[7]) - QW'(p_s4[8]);
			q_s6 <= q_s5;
			tb_s6 <= top_bit(max_q);
			for (int i = 0; i < 4; i++) begin
				if (tb_s6 > 6'(NORM_BIT)) begin
					q_s7[i] <= q_s6[i][QW-1]
						? NW'(64'd0 - (mag(q_s6[i]) >> (tb_s6 - 6'(NORM_BIT))))
						: NW'(mag(q_s6[i]) >> (tb_s6 - 6'(NORM_BIT)));
				end else begin
					q_s7[i] <= NW'(q_s6[i]);
				end
			end
		end
	end

	assign ctl_p = ctl_s7;
	assign q_p = q_s7;
endmodule

FILE: rtl/fnoa_isqrt.sv
// ----------------------------------------------------------------------------
// fnoa_isqrt
// Cross product length: squares, sum, then a restoring square root that
// settles one root bit per stage.
// ----------------------------------------------------------------------------
module fnoa_isqrt
	import fnoa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  fnoa_ctl_t            ctl_p,
	input  logic signed [NW-1:0] q_p [4],
	output fnoa_ctl_t            ctl_r,
	output logic signed [NW-1:0] dot_r,
	output logic [RW-1:0]        root_r
);
	fnoa_ctl_t ctl_s8;
	logic [SQW-1:0] sq_s8 [3];
	logic signed [NW-1:0] dot_s8;

	fnoa_ctl_t ctl_s [RW+1];
	logic [SQW-1:0] rem_s [RW+1];
	logic [RW-1:0] root_s [RW+1];
	logic signed [NW-1:0] dot_s [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s8 <= '0;
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s8 <= ctl_p;
			ctl_s[0] <= ctl_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s8[i] <= SQW'(q_p[i+1] * q_p[i+1]);
			end
			dot_s8 <= q_p[0];
			rem_s[0] <= sq_s8[0] + sq_s8[1] + sq_s8[2];
			root_s[0] <= '0;
			dot_s[0] <= dot_s8;
		end
	end

	for (genvar j = 0; j < RW; j++) begin : g_bit
		localparam int K = RW - 1 - j;
		logic [63:0] trial;
		logic fit;

		assign trial = (64'(root_s[j]) << (K + 1)) + (64'd1 << (2 * K));
		assign fit = 64'(rem_s[j]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j+1] <= '0;
			end else if (en) begin
				ctl_s[j+1] <= ctl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= fit ? SQW'(64'(rem_s[j]) - trial) : rem_s[j];
				root_s[j+1] <= fit ? (root_s[j] | (RW'(1) << K)) : root_s[j];
				dot_s[j+1] <= dot_s[j];
			end
		end
	end

	assign ctl_r = ctl_s[RW];
	assign dot_r = dot_s[RW];
	assign root_r = root_s[RW];

	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[RW].vld |-> (64'(rem_s[RW]) <= (64'(root_s[RW]) << 1)))
		else $error("square root remainder too large");
endmodule

FILE: rtl/fnoa_cordic.sv
// ----------------------------------------------------------------------------
// fnoa_cordic
// Vectoring CORDIC for atan2(|d x S|, d.S) in degrees, one iteration per
// stage, then clamp and rounding to the output format.
// ----------------------------------------------------------------------------
module fnoa_cordic
	import fnoa_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  fnoa_ctl_t            ctl_r,
	input  logic signed [NW-1:0] dot_r,
	input  logic [RW-1:0]        root_r,
	output fnoa_ctl_t            ctl_c,
	output logic [OUT_W-1:0]     angle_c
);
	localparam int SH = ZQ - ANGLE_FRAC_BITS;
	localparam logic [ZW:0] HALF = (ZW+1)'(1) << (SH - 1);
	localparam logic [ZW:0] OUT_MAX = (ZW+1)'(2 ** OUT_W - 1);
	localparam logic [ZW:0] A90_RAW = ((ZW+1)'(Z90) + HALF) >> SH;
	localparam logic [OUT_W-1:0] A90 = (A90_RAW > OUT_MAX) ? '1 : OUT_W'(A90_RAW);

	fnoa_ctl_t ctl_s [CORDIC_ITERS+1];
	logic signed [XW-1:0] x_s [CORDIC_ITERS+1];
	logic signed [XW-1:0] y_s [CORDIC_ITERS+1];
	logic signed [ZW-1:0] z_s [CORDIC_ITERS+1];
	fnoa_ctl_t ctl_sf;
	logic [OUT_W-1:0] angle_sf;
	logic signed [ZW-1:0] z_clamp;
	logic [ZW:0] z_round;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dot_r < 0) begin
				x_s[0] <= XW'(root_r);
				y_s[0] <= -XW'(dot_r);
				z_s[0] <= Z90;
			end else begin
				x_s[0] <= XW'(dot_r);
				y_s[0] <= XW'(root_r);
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
		logic signed [XW-1:0] xs, ys;

		assign xs = x_s[i][XW-1] ? -((-x_s[i]) >>> i) : (x_s[i] >>> i);
		assign ys = y_s[i][XW-1] ? -((-y_s[i]) >>> i) : (y_s[i] >>> i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + atan_q24(i);
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - atan_q24(i);
				end
			end
		end
	end

	always_comb begin
		if (ctl_s[CORDIC_ITERS].zero) begin
			z_clamp = Z90;
		end else if (z_s[CORDIC_ITERS] < 0) begin
			z_clamp = '0;
		end else if (z_s[CORDIC_ITERS] > Z180) begin
			z_clamp = Z180;
		end else begin
			z_clamp = z_s[CORDIC_ITERS];
		end
		z_round = ((ZW+1)'(unsigned'(z_clamp)) + HALF) >> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sf <= '0;
		end else if (en) begin
			ctl_sf <= ctl_s[CORDIC_ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_sf <= (z_round > OUT_MAX) ? '1 : OUT_W'(z_round);
		end
	end

	assign ctl_c = ctl_sf;
	assign angle_c = angle_sf;

	a_zero_right_angle: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl_s[CORDIC_ITERS].vld && ctl_s[CORDIC_ITERS].zero |=> angle_sf == A90)
		else $error("zero vector did not give a right angle");
endmodule

FILE: rtl/face_non_orthogonality_angle.sv
// ----------------------------------------------------------------------------
// face_non_orthogonality_angle
// Angle between the owner-to-neighbour vector of a face and its area vector,
// in degrees, unsigned fixed point with ANGLE_FRAC_BITS fraction bits.
//
//   channel    dir  beat
//   in_face    in   owner, neighbour and area vectors of one face
//   out_angle  out  angle_degrees of that face
//
// one face per cycle unless the pipeline is frozen; stages: 3 normalize, 4 products,
// 33 root, 30 cordic, 1 output register
// the root and the cordic settle one bit or one iteration per stage
// reset clears only the valid and zero flags; no state carries between faces
// a stalled output holds in its register while the pipeline keeps filling;
// the pipeline freezes only when its last stage and the output are both full
// ----------------------------------------------------------------------------
module face_non_orthogonality_angle
	import fnoa_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	fnoa_face_if.sink           in_face,
	fnoa_angle_if.source        out_angle
);
	localparam logic [31:0] MAX_ANGLE = (ANGLE_FRAC_BITS > 8) ? 32'hffff
		: (32'd180 << ANGLE_FRAC_BITS);

	logic adv;
	fnoa_ctl_t ctl_in, ctl_n, ctl_p, ctl_r, ctl_c;
	logic signed [COORD_WIDTH-1:0] owner [3];
	logic signed [COORD_WIDTH-1:0] neighbour [3];
	logic signed [COORD_WIDTH-1:0] area [3];
	logic signed [NW-1:0] d_n [3];
	logic signed [NW-1:0] s_n [3];
	logic signed [NW-1:0] q_p [4];
	logic signed [NW-1:0] dot_r;
	logic [RW-1:0] root_r;
	logic [OUT_W-1:0] angle_c;
	logic out_vld_q;
	logic [OUT_W-1:0] angle_q;

	assign adv = !ctl_c.vld || !out_vld_q || out_angle.ready;
	assign in_face.ready = adv;
	assign ctl_in.vld = in_face.valid;
	assign ctl_in.zero = 1'b0;

	assign owner[0] = in_face.owner_x;
	assign owner[1] = in_face.owner_y;
	assign owner[2] = in_face.owner_z;
	assign neighbour[0] = in_face.neighbour_x;
	assign neighbour[1] = in_face.neighbour_y;
	assign neighbour[2] = in_face.neighbour_z;
	assign area[0] = in_face.area_x;
	assign area[1] = in_face.area_y;
	assign area[2] = in_face.area_z;

	fnoa_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm (
		.clk(clk), .arst_n(arst_n), .en(adv), .ctl(ctl_in),
		.owner(owner), .neighbour(neighbour), .area(area),
		.ctl_n(ctl_n), .d_n(d_n), .s_n(s_n)
	);

	fnoa_prod u_prod (
		.clk(clk), .arst_n(arst_n), .en(adv), .ctl_n(ctl_n),
		.d_n(d_n), .s_n(s_n), .ctl_p(ctl_p), .q_p(q_p)
	);

	fnoa_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(adv), .ctl_p(ctl_p),
		.q_p(q_p), .ctl_r(ctl_r), .dot_r(dot_r), .root_r(root_r)
	);

	fnoa_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(adv), .ctl_r(ctl_r),
		.dot_r(dot_r), .root_r(root_r), .ctl_c(ctl_c), .angle_c(angle_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || out_angle.ready) begin
			out_vld_q <= ctl_c.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_angle.ready) begin
			angle_q <= angle_c;
		end
	end

	assign out_angle.valid = out_vld_q;
	assign out_angle.angle_degrees = angle_q;

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> 32'(angle_q) <= MAX_ANGLE)
		else $error("angle above 180 degrees");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c.vld && out_vld_q && !out_angle.ready |=> ctl_c.vld && $stable(angle_c))
		else $error("finished beat lost while stalled");
endmodule
